// ----- rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and control/status structs of the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_PAGES     = 65536;
    localparam int MAP_WORD_BITS = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int MAP_WORDS     = MAX_PAGES / MAP_WORD_BITS;

    localparam int KB_W       = 22;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int WIDX_W     = $clog2(MAP_WORDS);
    localparam int BIDX_W     = $clog2(MAP_WORD_BITS);
    localparam int IN_ADDR_W  = 48;
    localparam int OUT_ADDR_W = 28;
    localparam int PGIDX_W    = IN_ADDR_W - PAGE_SHIFT;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;

    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [MAP_WORD_BITS-1:0] t_word;
    typedef logic [WIDX_W-1:0]        t_widx;
    typedef logic [BIDX_W-1:0]        t_bidx;
    typedef logic [PGIDX_W-1:0]       t_pgidx;
    typedef logic [OUT_ADDR_W-1:0]    t_oaddr;
    typedef logic [REQ_W-1:0]         t_req;
    typedef logic [STAT_W-1:0]        t_stat;
    typedef logic [1:0]               t_res;

    localparam t_req REQ_INIT  = 2'd0;
    localparam t_req REQ_ALLOC = 2'd1;
    localparam t_req REQ_FREE  = 2'd2;

    localparam t_stat ST_OK  = 2'd0;
    localparam t_stat ST_OOM = 2'd1;
    localparam t_stat ST_IGN = 2'd2;

    localparam t_res RES_HOLD = 2'd0;
    localparam t_res RES_OK   = 2'd1;
    localparam t_res RES_OOM  = 2'd2;
    localparam t_res RES_IGN  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_KB      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 1'b1;

    localparam logic [KB_W-1:0] MEMORY_KB_RESET = 22'd262144;

    typedef struct packed {
        logic in_ready;
        logic load_req;
        logic init_setup;
        logic sweep_wr;
        logic scan_setup;
        logic free_setup;
        logic map_rd;
        logic alloc_chk;
        logic free_chk;
        t_res res_sel;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_req req_type;
        logic hint_oob;
        logic free_oob;
        logic sweep_last;
        logic found;
        logic scan_end;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/bpa_req_if.sv -----
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: valid/ready handshake with request type and page address.
// ----------------------------------------------------------------------------
interface bpa_req_if;
    logic                              valid;
    logic                              ready;
    logic [bpa_pkg::REQ_W-1:0]         req_type;
    logic [bpa_pkg::IN_ADDR_W-1:0]     page_address;

    modport source (output valid, req_type, page_address, input ready);
    modport sink   (input valid, req_type, page_address, output ready);
endinterface

// ----- rtl/bpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Response channel: valid/ready handshake with address, status and free count.
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bpa_pkg::OUT_ADDR_W-1:0]    alloc_address;
    logic [bpa_pkg::STAT_W-1:0]        status;
    logic [bpa_pkg::CNT_W-1:0]         free_pages;

    modport source (output valid, alloc_address, status, free_pages, input ready);
    modport sink   (input valid, alloc_address, status, free_pages, output ready);
endinterface

// ----- rtl/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: dispatches requests, drives map sweeps, scans and the result slot.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_SWEEP = 4'd3;
    localparam logic [3:0] S_ARD   = 4'd4;
    localparam logic [3:0] S_ACHK  = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req_type)
                    bpa_pkg::REQ_INIT: begin
                        o_cmd.init_setup = 1'b1;
                        n_state          = S_SWEEP;
                    end
                    bpa_pkg::REQ_ALLOC: begin
                        if (i_sts.hint_oob) begin
                            o_cmd.res_sel = bpa_pkg::RES_OOM;
                            n_state       = S_OUT;
                        end else begin
                            o_cmd.scan_setup = 1'b1;
                            n_state          = S_ARD;
                        end
                    end
                    bpa_pkg::REQ_FREE: begin
                        if (i_sts.free_oob) begin
                            o_cmd.res_sel = bpa_pkg::RES_IGN;
                            n_state       = S_OUT;
                        end else begin
                            o_cmd.free_setup = 1'b1;
                            n_state          = S_FRD;
                        end
                    end
                    default: begin
                        o_cmd.res_sel = bpa_pkg::RES_OK;
                        n_state       = S_OUT;
                    end
                endcase
            end
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.res_sel = bpa_pkg::RES_OK;
                    n_state       = S_OUT;
                end
            end
            S_ARD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_ACHK;
            end
            S_ACHK: begin
                o_cmd.alloc_chk = 1'b1;
                if (i_sts.found || i_sts.scan_end) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ARD;
                end
            end
            S_FRD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_FCHK;
            end
            S_FCHK: begin
                o_cmd.free_chk = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bpa_dp.sv -----
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: page map memory, counters, search hint, scan logic, result slot.
// ----------------------------------------------------------------------------
module bpa_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [bpa_pkg::KB_W-1:0]              i_cfg_data,
    input  logic [bpa_pkg::REQ_W-1:0]             i_req_type,
    input  logic [bpa_pkg::IN_ADDR_W-1:0]         i_page_address,
    input  bpa_pkg::t_cmd                         i_cmd,
    output bpa_pkg::t_sts                         o_sts,
    bpa_rsp_if.source                             o_rsp
);

    bpa_pkg::t_word r_map [bpa_pkg::MAP_WORDS];
    bpa_pkg::t_word r_rd_data;

    logic [bpa_pkg::KB_W-1:0] r_memory_kb;
    bpa_pkg::t_cnt            r_reserved_pages;
    bpa_pkg::t_cnt            r_active;
    bpa_pkg::t_cnt            r_free;
    bpa_pkg::t_cnt            r_hint;
    bpa_pkg::t_cnt            r_sweep_resv;
    bpa_pkg::t_widx           r_word_idx;
    logic                     r_first;
    logic                     r_out_valid;

    bpa_pkg::t_req            r_req_type;
    bpa_pkg::t_pgidx          r_pg_idx;
    bpa_pkg::t_oaddr          r_res_addr;
    bpa_pkg::t_stat           r_res_status;
    bpa_pkg::t_oaddr          r_out_addr;
    bpa_pkg::t_stat           r_out_status;
    bpa_pkg::t_cnt            r_out_free;

    logic [bpa_pkg::KB_W-3:0] w_pages_raw;
    bpa_pkg::t_cnt            w_pages;
    bpa_pkg::t_cnt            w_resv;
    bpa_pkg::t_cnt            w_base;
    bpa_pkg::t_cnt            w_base_top;
    bpa_pkg::t_cnt            w_resv_off;
    bpa_pkg::t_cnt            w_lim_off;
    bpa_pkg::t_word           w_sweep_mask;
    bpa_pkg::t_word           w_lim_mask;
    bpa_pkg::t_word           w_lo_mask;
    bpa_pkg::t_word           w_cand;
    bpa_pkg::t_bidx           w_ff;
    logic                     w_found;
    logic                     w_scan_end;
    bpa_pkg::t_word           w_ff_bit;
    bpa_pkg::t_word           w_free_bit;
    logic                     w_free_set;
    bpa_pkg::t_cnt            w_free_pg;
    logic                     w_map_we;
    bpa_pkg::t_word           w_map_wd;

    assign w_pages_raw = r_memory_kb[bpa_pkg::KB_W-1:2];
    assign w_pages     = (w_pages_raw > (bpa_pkg::KB_W-2)'(bpa_pkg::MAX_PAGES))
                         ? bpa_pkg::t_cnt'(bpa_pkg::MAX_PAGES)
                         : bpa_pkg::t_cnt'(w_pages_raw);
    assign w_resv      = (r_reserved_pages > bpa_pkg::t_cnt'(bpa_pkg::MAX_PAGES))
                         ? bpa_pkg::t_cnt'(bpa_pkg::MAX_PAGES) : r_reserved_pages;

    assign w_base     = bpa_pkg::t_cnt'({r_word_idx, bpa_pkg::t_bidx'(0)});
    assign w_base_top = w_base + bpa_pkg::t_cnt'(bpa_pkg::MAP_WORD_BITS);
    assign w_resv_off = r_sweep_resv - w_base;
    assign w_lim_off  = r_active - w_base;

    always_comb begin
        if (r_sweep_resv >= w_base_top) begin
            w_sweep_mask = '1;
        end else if (r_sweep_resv <= w_base) begin
            w_sweep_mask = '0;
        end else begin
            w_sweep_mask = ~(bpa_pkg::t_word'('1) << w_resv_off[bpa_pkg::BIDX_W-1:0]);
        end
    end

    always_comb begin
        if (r_active >= w_base_top) begin
            w_lim_mask = '1;
        end else begin
            w_lim_mask = ~(bpa_pkg::t_word'('1) << w_lim_off[bpa_pkg::BIDX_W-1:0]);
        end
        w_lo_mask = r_first ? (bpa_pkg::t_word'('1) << r_hint[bpa_pkg::BIDX_W-1:0])
                            : bpa_pkg::t_word'('1);
        w_cand    = ~r_rd_data & w_lim_mask & w_lo_mask;
    end

    always_comb begin
        w_ff = '0;
        for (int b = bpa_pkg::MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_ff = bpa_pkg::t_bidx'(b);
            end
        end
    end

    assign w_found    = |w_cand;
    assign w_scan_end = (r_word_idx == bpa_pkg::t_widx'(bpa_pkg::MAP_WORDS - 1))
                        || (w_base_top >= r_active);
    assign w_ff_bit   = bpa_pkg::t_word'(1) << w_ff;
    assign w_free_bit = bpa_pkg::t_word'(1) << r_pg_idx[bpa_pkg::BIDX_W-1:0];
    assign w_free_set = r_rd_data[r_pg_idx[bpa_pkg::BIDX_W-1:0]];
    assign w_free_pg  = bpa_pkg::t_cnt'(r_pg_idx[bpa_pkg::PAGE_W-1:0]);

    always_comb begin
        w_map_we = 1'b0;
        w_map_wd = w_sweep_mask;
        if (i_cmd.sweep_wr) begin
            w_map_we = 1'b1;
        end else if (i_cmd.alloc_chk && w_found) begin
            w_map_we = 1'b1;
            w_map_wd = r_rd_data | w_ff_bit;
        end else if (i_cmd.free_chk && w_free_set) begin
            w_map_we = 1'b1;
            w_map_wd = r_rd_data & ~w_free_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map[r_word_idx] <= w_map_wd;
        end
        if (i_cmd.map_rd) begin
            r_rd_data <= r_map[r_word_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_memory_kb      <= bpa_pkg::MEMORY_KB_RESET;
            r_reserved_pages <= '0;
            r_active         <= '0;
            r_free           <= '0;
            r_hint           <= '0;
            r_sweep_resv     <= '0;
            r_word_idx       <= '0;
            r_first          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bpa_pkg::CFG_MEMORY_KB) begin
                    r_memory_kb <= i_cfg_data;
                end else begin
                    r_reserved_pages <= i_cfg_data[bpa_pkg::CNT_W-1:0];
                end
            end
            if (i_cmd.init_setup) begin
                r_active     <= w_pages;
                r_free       <= (w_pages > w_resv) ? w_pages - w_resv : '0;
                r_hint       <= '0;
                r_sweep_resv <= w_resv;
                r_word_idx   <= '0;
            end
            if (i_cmd.sweep_wr) begin
                r_word_idx <= r_word_idx + 1'b1;
            end
            if (i_cmd.scan_setup) begin
                r_word_idx <= r_hint[bpa_pkg::PAGE_W-1:bpa_pkg::BIDX_W];
                r_first    <= 1'b1;
            end
            if (i_cmd.free_setup) begin
                r_word_idx <= r_pg_idx[bpa_pkg::PAGE_W-1:bpa_pkg::BIDX_W];
            end
            if (i_cmd.alloc_chk) begin
                if (w_found) begin
                    r_hint <= bpa_pkg::t_cnt'({r_word_idx, w_ff}) + 1'b1;
                    if (r_free != '0) begin
                        r_free <= r_free - 1'b1;
                    end
                end else if (!w_scan_end) begin
                    r_word_idx <= r_word_idx + 1'b1;
                    r_first    <= 1'b0;
                end
            end
            if (i_cmd.free_chk && w_free_set) begin
                if (r_free < bpa_pkg::t_cnt'(bpa_pkg::MAX_PAGES)) begin
                    r_free <= r_free + 1'b1;
                end
                if (w_free_pg < r_hint) begin
                    r_hint <= w_free_pg;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req_type;
            r_pg_idx   <= i_page_address[bpa_pkg::IN_ADDR_W-1:bpa_pkg::PAGE_SHIFT];
        end
        case (i_cmd.res_sel)
            bpa_pkg::RES_OK: begin
                r_res_addr   <= '0;
                r_res_status <= bpa_pkg::ST_OK;
            end
            bpa_pkg::RES_OOM: begin
                r_res_addr   <= '0;
                r_res_status <= bpa_pkg::ST_OOM;
            end
            bpa_pkg::RES_IGN: begin
                r_res_addr   <= '0;
                r_res_status <= bpa_pkg::ST_IGN;
            end
            default: begin
            end
        endcase
        if (i_cmd.alloc_chk) begin
            if (w_found) begin
                r_res_addr   <= bpa_pkg::t_oaddr'({r_word_idx, w_ff,
                                                   {bpa_pkg::PAGE_SHIFT{1'b0}}});
                r_res_status <= bpa_pkg::ST_OK;
            end else if (w_scan_end) begin
                r_res_addr   <= '0;
                r_res_status <= bpa_pkg::ST_OOM;
            end
        end
        if (i_cmd.free_chk) begin
            r_res_addr   <= '0;
            r_res_status <= w_free_set ? bpa_pkg::ST_OK : bpa_pkg::ST_IGN;
        end
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_free   <= r_free;
        end
    end

    assign o_sts.req_type   = r_req_type;
    assign o_sts.hint_oob   = r_hint >= r_active;
    assign o_sts.free_oob   = r_pg_idx >= bpa_pkg::t_pgidx'(r_active);
    assign o_sts.sweep_last = r_word_idx == bpa_pkg::t_widx'(bpa_pkg::MAP_WORDS - 1);
    assign o_sts.found      = w_found;
    assign o_sts.scan_end   = w_scan_end;
    assign o_sts.out_busy   = r_out_valid && !o_rsp.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.alloc_address = r_out_addr;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.free_pages    = r_out_free;

    a_free_le_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_active)
        else $error("free count above page count");

    a_hint_le_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= r_active)
        else $error("search hint above page count");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.alloc_chk && w_found) |=>
        (bpa_pkg::t_cnt'(r_res_addr[bpa_pkg::OUT_ADDR_W-1:bpa_pkg::PAGE_SHIFT]) < r_active))
        else $error("allocated page outside active range");

endmodule

// ----- rtl/bitmap_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// Page frame allocator over a one-bit-per-page map with a lowest-free hint.
// ----------------------------------------------------------------------------
// Sequence, accept to response valid: undefined and dispatch-refused requests go
// straight to output; a free reads and checks one map word; an allocate reads and
// checks each word it scans; init is set by the one-word-a-cycle 1024-word sweep.
// Throughput: one request at a time; the next is taken the cycle after the
// response is loaded, while that response may still wait in the output register.
// Reset: a clearing pass over the 1024-word map; configuration writes taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpa_pkg::KB_W-1:0]      i_cfg_data,
    bpa_req_if.sink                       i_req,
    bpa_rsp_if.source                     o_rsp
);

    bpa_pkg::t_cmd w_cmd;
    bpa_pkg::t_sts w_sts;

    assign i_req.ready = w_cmd.in_ready;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bpa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req.req_type),
        .i_page_address (i_req.page_address),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_rsp          (o_rsp)
    );

endmodule
